FILE: rtl/wait_run_condenser_defines.svh
// Assertion macros shared by the wait run condenser RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef WAIT_RUN_CONDENSER_DEFINES_SVH
`define WAIT_RUN_CONDENSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WRC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wait_run_condenser assertion failed");

// Next-cycle implication, disabled during reset.
`define WRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wait_run_condenser assertion failed");

`endif

FILE: rtl/wrc_pkg.sv
// Types, opcode constants and the opcode length table of the wait run condenser.
// Depends on nothing.
package wrc_pkg;

    localparam int BYTE_W      = 8;
    localparam int RUN_W       = 16;
    localparam int LEFT_W      = 3;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int SLOT_IDX_W  = 4;
    localparam int SLOTS_PER_REG = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_BURST   = 4;

    localparam logic [BYTE_W-1:0] WAIT_OP      = 8'hfe;
    localparam logic [BYTE_W-1:0] NOP_OP       = 8'hf1;
    localparam logic [BYTE_W-1:0] LONG_WAIT_OP = 8'hfc;
    localparam logic [BYTE_W-1:0] WAIT_N_OP    = 8'hfd;
    localparam logic [BYTE_W-1:0] SLOT_BASE_OP = 8'he0;
    localparam logic [RUN_W-1:0]  RUN_MAX      = 16'hffff;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY_SLOTS_LOW  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_SLOTS_HIGH = 4'd1;

    // One classified input byte, handed from front to back.
    typedef struct packed {
        logic [RUN_W-1:0]  run;       // wait run to flush first, zero for none
        logic              has_byte;  // data byte follows the flushed run
        logic [BYTE_W-1:0] data;
        logic              last;      // byte carried stream_end
        logic              flag;      // parse halted
    } wrc_entry_t;

    function automatic logic [LEFT_W-1:0] opcode_length(input logic [BYTE_W-1:0] op);
        logic [LEFT_W-1:0] len;
        case (op) inside
            8'hb8, 8'hc0, 8'hc3, 8'hc4, 8'hc5, 8'hc7, 8'hca, 8'hfd: len = 3'd2;
            8'hbe, 8'hc2, 8'hc6, 8'hc8, 8'hc9, 8'hf8, 8'hfc:        len = 3'd3;
            8'hf0:                                                  len = 3'd4;
            8'hf4, 8'hf5, 8'hf6, 8'hfa, 8'hfb:                      len = 3'd5;
            8'hf2, 8'hf7, [8'hd0:8'hdf]:                            len = 3'd0;
            default:                                                len = 3'd1;
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/wrc_in_if.sv
// Input byte channel of the wait run condenser.
// Depends on wrc_pkg.
interface wrc_in_if;
    import wrc_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              stream_end;

    modport source (output valid, output in_byte, output stream_end, input ready);
    modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

FILE: rtl/wrc_out_if.sv
// Condensed byte channel of the wait run condenser.
// Depends on wrc_pkg.
interface wrc_out_if;
    import wrc_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              out_end;
    logic              bad_opcode;

    modport source (output valid, output out_byte, output run_last, output out_end,
                    output bad_opcode, input ready);
    modport sink   (input valid, input out_byte, input run_last, input out_end,
                    input bad_opcode, output ready);
endinterface

FILE: rtl/wrc_cfg_if.sv
// Configuration write channel of the wait run condenser.
// Depends on wrc_pkg.
interface wrc_cfg_if;
    import wrc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/wait_run_condenser.sv
// Top level of the wait run condenser: front end, entry queue, back end.
// Depends on wrc_pkg, the three channel interfaces, wrc_front, wrc_queue, wrc_back.

// Accepts one command byte per cycle and emits the condensed stream at one byte
// per cycle while the sink is ready. A byte that yields k output bytes (0 to 4:
// a flushed wait run of up to three bytes, then the byte itself) forms a burst;
// a four entry queue between the parser and the encoder absorbs such bursts,
// and input stalls only while that queue is full. An accepted byte goes through
// the queue register and then the back end output register before its first
// output byte. The user writes the delay slot registers on the cfg channel only
// while the block is idle, which the block does not enforce; no clearing pass follows reset.
module wait_run_condenser #(
    parameter int DELAY_SLOTS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    wrc_in_if.sink    stream,
    wrc_out_if.source condensed,
    wrc_cfg_if.sink   cfg
);
    import wrc_pkg::*;

    wrc_entry_t front_entry, head_entry;
    logic       push_valid, push_ready;
    logic       head_valid, head_ready;

    wrc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream),
        .entry      (front_entry),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    wrc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_entry (front_entry),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_entry  (head_entry),
        .pop_valid  (head_valid),
        .pop_ready  (head_ready)
    );

    wrc_back #(
        .DELAY_SLOTS (DELAY_SLOTS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head       (head_entry),
        .head_valid (head_valid),
        .head_ready (head_ready),
        .condensed  (condensed)
    );

endmodule

FILE: rtl/wrc_front.sv
// Front end: tracks instruction boundaries and wait runs, one byte per cycle while the
// queue has room, and hands one classified entry per byte that yields output. Depends on wrc_pkg.
module wrc_front (
    input  logic              clk,
    input  logic              rst_n,
    wrc_in_if.sink            stream,
    output wrc_pkg::wrc_entry_t entry,
    output logic              push_valid,
    input  logic              push_ready
);
    import wrc_pkg::*;

    logic [LEFT_W-1:0] left_reg, left_next;
    logic [RUN_W-1:0]  run_reg, run_next;
    logic              halted_reg, halted_next;
    logic [RUN_W-1:0]  run_inc;
    logic [LEFT_W-1:0] len;
    logic              accept;

    assign stream.ready = push_ready;
    assign accept       = stream.valid && push_ready;
    assign run_inc      = run_reg + 16'd1;
    assign len          = opcode_length(stream.in_byte);

    always_comb
    begin
        left_next      = left_reg;
        run_next       = run_reg;
        halted_next    = halted_reg;
        entry.run      = '0;
        entry.has_byte = 1'b0;
        entry.data     = stream.in_byte;
        entry.last     = stream.stream_end;
        if (halted_reg)
        begin
            entry.has_byte = 1'b1;
        end
        else if (left_reg != '0)
        begin
            entry.has_byte = 1'b1;
            left_next      = left_reg - 3'd1;
        end
        else if (len == '0)
        begin
            entry.run      = run_reg;
            run_next       = '0;
            entry.has_byte = 1'b1;
            halted_next    = 1'b1;
        end
        else if (stream.in_byte == WAIT_OP)
        begin
            // saturated run goes out at once and the count restarts
            if (run_inc == RUN_MAX)
            begin
                entry.run = run_inc;
                run_next  = '0;
            end
            else
            begin
                run_next = run_inc;
            end
        end
        else
        begin
            entry.run      = run_reg;
            run_next       = '0;
            entry.has_byte = (stream.in_byte != NOP_OP);
            left_next      = len - 3'd1;
        end
        entry.flag = halted_next;
        if (stream.stream_end)
        begin
            // only an open run leaves run_next set, and then entry.run is zero
            if (run_next != '0)
            begin
                entry.run = run_next;
            end
            left_next   = '0;
            run_next    = '0;
            halted_next = 1'b0;
        end
    end

    assign push_valid = stream.valid && (entry.has_byte || (entry.run != '0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            run_reg    <= '0;
            halted_reg <= 1'b0;
        end
        else if (accept)
        begin
            left_reg   <= left_next;
            run_reg    <= run_next;
            halted_reg <= halted_next;
        end
    end

endmodule

FILE: rtl/wrc_queue.sv
// Short entry queue between front and back of the wait run condenser.
// Depends on wrc_pkg and wait_run_condenser_defines.svh.
`include "wait_run_condenser_defines.svh"
module wrc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  wrc_pkg::wrc_entry_t push_entry,
    input  logic                push_valid,
    output logic                push_ready,
    output wrc_pkg::wrc_entry_t pop_entry,
    output logic                pop_valid,
    input  logic                pop_ready
);
    import wrc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    wrc_entry_t       mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             push, pop;

    assign push_ready = (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_entry  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    `WRC_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(QUEUE_DEPTH))
    `WRC_ASSERT_NEXT(a_cnt_up, clk, rst_n, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1)
    `WRC_ASSERT_IMPL(a_ptr_gap, clk, rst_n, cnt_reg != CNT_W'(QUEUE_DEPTH),
                     PTR_W'(wr_ptr_reg - rd_ptr_reg) == PTR_W'(cnt_reg))

endmodule

FILE: rtl/wrc_back.sv
// Back end: encodes the flushed wait run against the delay slots and sends the
// entry's bytes out one per cycle while the sink is ready. Holds the slot registers. Depends on wrc_pkg.
`include "wait_run_condenser_defines.svh"
module wrc_back #(
    parameter int DELAY_SLOTS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    wrc_cfg_if.sink             cfg,
    input  wrc_pkg::wrc_entry_t head,
    input  logic                head_valid,
    output logic                head_ready,
    wrc_out_if.source           condensed
);
    import wrc_pkg::*;

    localparam int POS_W = $clog2(MAX_BURST);
    localparam int CNT_W = $clog2(MAX_BURST + 1);

    logic [DELAY_SLOTS-1:0][BYTE_W-1:0] slots_reg;
    logic [BYTE_W-1:0] bytes_reg [MAX_BURST];
    logic [CNT_W-1:0]  cnt_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              valid_reg, last_reg, flag_reg;

    logic [BYTE_W-1:0]     enc_bytes [MAX_BURST];
    logic [CNT_W-1:0]      enc_cnt;
    logic [POS_W-1:0]      run_len;
    logic                  match;
    logic [SLOT_IDX_W-1:0] match_idx;
    logic                  take, at_last, done;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= '0;
        end
        else if (cfg.valid)
        begin
            for (int j = 0; j < DELAY_SLOTS; j++)
            begin
                if (j < SLOTS_PER_REG && cfg.index == REG_DELAY_SLOTS_LOW)
                begin
                    slots_reg[j] <= cfg.data[BYTE_W*(j % SLOTS_PER_REG) +: BYTE_W];
                end
                if (j >= SLOTS_PER_REG && cfg.index == REG_DELAY_SLOTS_HIGH)
                begin
                    slots_reg[j] <= cfg.data[BYTE_W*(j % SLOTS_PER_REG) +: BYTE_W];
                end
            end
        end
    end

    // lowest matching slot wins: scan downward so lower indexes override
    always_comb
    begin
        match     = 1'b0;
        match_idx = '0;
        for (int j = DELAY_SLOTS - 1; j >= 0; j--)
        begin
            if (slots_reg[j] == head.run[BYTE_W-1:0])
            begin
                match     = 1'b1;
                match_idx = SLOT_IDX_W'(j);
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < MAX_BURST; k++)
        begin
            enc_bytes[k] = head.data;
        end
        if (head.run == '0)
        begin
            run_len = 2'd0;
        end
        else if (head.run == 16'd1)
        begin
            enc_bytes[0] = WAIT_OP;
            run_len      = 2'd1;
        end
        else if (head.run[RUN_W-1:BYTE_W] != '0)
        begin
            enc_bytes[0] = LONG_WAIT_OP;
            enc_bytes[1] = head.run[BYTE_W-1:0];
            enc_bytes[2] = head.run[RUN_W-1:BYTE_W];
            run_len      = 2'd3;
        end
        else if (match)
        begin
            enc_bytes[0] = SLOT_BASE_OP | {{(BYTE_W-SLOT_IDX_W){1'b0}}, match_idx};
            run_len      = 2'd1;
        end
        else
        begin
            enc_bytes[0] = WAIT_N_OP;
            enc_bytes[1] = head.run[BYTE_W-1:0];
            run_len      = 2'd2;
        end
        enc_cnt = CNT_W'(run_len) + CNT_W'(head.has_byte);
    end

    assign take       = valid_reg && condensed.ready;
    assign at_last    = (CNT_W'(pos_reg) == cnt_reg - 1'b1);
    assign done       = !valid_reg || (take && at_last);
    assign head_ready = done;

    assign condensed.valid      = valid_reg;
    assign condensed.out_byte   = bytes_reg[pos_reg];
    assign condensed.run_last   = at_last;
    assign condensed.out_end    = at_last && last_reg;
    assign condensed.bad_opcode = flag_reg;

    always_ff @(posedge clk)
    begin
        if (done && head_valid)
        begin
            for (int k = 0; k < MAX_BURST; k++)
            begin
                bytes_reg[k] <= enc_bytes[k];
            end
            cnt_reg  <= enc_cnt;
            last_reg <= head.last;
            flag_reg <= head.flag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else if (done)
        begin
            valid_reg <= head_valid;
            pos_reg   <= '0;
        end
        else if (take)
        begin
            pos_reg <= pos_reg + 1'b1;
        end
    end

    `WRC_ASSERT_IMPL(a_pos_in_burst, clk, rst_n, valid_reg, CNT_W'(pos_reg) < cnt_reg)
    `WRC_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, valid_reg && !condensed.ready,
                     valid_reg && pos_reg == $past(pos_reg))
    `WRC_ASSERT_NEXT(a_step_inside, clk, rst_n, take && !at_last,
                     valid_reg && pos_reg == $past(pos_reg) + 1'b1)

endmodule
